[hdl/squitter_frame_check_assert.svh]
// Assertion macros for the squitter frame checker, used by sfc_line_check.
// Expects signals clk and rst in the scope of each use.
`ifndef SQUITTER_FRAME_CHECK_ASSERT_SVH
`define SQUITTER_FRAME_CHECK_ASSERT_SVH

// Same-cycle implication, muted during reset.
`define SFC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("squitter frame check: assertion failed");

// Next-cycle implication, muted during reset.
`define SFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("squitter frame check: assertion failed");

`endif

[hdl/sfc_pkg.sv]
// Types, constants and helper functions for the squitter frame checker.
// No dependencies.
package sfc_pkg;

  localparam logic [23:0] CRC_POLY     = 24'hFFF409;
  localparam logic [4:0]  FORMAT_ES    = 5'd17;
  localparam logic [4:0]  LINE_LEN     = 5'd30;
  localparam logic [4:0]  HEX_LEN      = 5'd28;
  localparam logic [4:0]  CRC_NIBBLES  = 5'd22;
  localparam logic [4:0]  COUNT_MAX    = 5'd31;
  localparam logic [7:0]  MARK_START   = 8'h2A;
  localparam logic [7:0]  MARK_END     = 8'h3B;

  localparam logic        KIND_CHAR    = 1'b0;
  localparam logic        KIND_EOL     = 1'b1;

  localparam logic [1:0]  STATUS_OK    = 2'd0;
  localparam logic [1:0]  STATUS_FRAME = 2'd1;
  localparam logic [1:0]  STATUS_DATA  = 2'd2;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_byte;
  } sfc_beat_t;

  typedef struct packed {
    logic [23:0] stated_parity;
    logic [55:0] payload;
    logic [4:0]  type_code;
    logic [23:0] icao_address;
    logic [2:0]  capability;
    logic [4:0]  downlink_format;
    logic [1:0]  status;
  } sfc_result_t;

  // Bit 4 set means not a hex digit; low nibble is the value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h57)};
    end
    return v;
  endfunction

  // Four MSB-first CRC-24 steps.
  function automatic logic [23:0] crc_nibble(input logic [23:0] crc, input logic [3:0] nib);
    logic [23:0] c;
    c = crc;
    for (int b = 3; b >= 0; b--) begin
      if (nib[b] ^ c[23]) begin
        c = {c[22:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[22:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[hdl/sfc_in_stage.sv]
// Input register of the squitter frame checker: holds one beat until consumed.
// Depends on sfc_pkg.
module sfc_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_valid,
  output logic              s_ready,
  input  sfc_pkg::sfc_beat_t s_beat,
  output logic              beat_valid,
  output sfc_pkg::sfc_beat_t beat,
  input  logic              beat_take
);
  import sfc_pkg::*;

  assign s_ready = !beat_valid || beat_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (s_ready) begin
      beat_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      beat <= s_beat;
    end
  end

endmodule

[hdl/sfc_line_check.sv]
// Line accumulator and verdict logic: hex decode, frame shift chain, CRC-24.
// Depends on sfc_pkg and squitter_frame_check_assert.svh.
module sfc_line_check (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 beat_valid,
  input  sfc_pkg::sfc_beat_t   beat,
  output logic                 beat_take,
  input  logic                 res_ready,
  output logic                 res_valid,
  output sfc_pkg::sfc_result_t res
);
  import sfc_pkg::*;
  `include "squitter_frame_check_assert.svh"

  logic [4:0]  char_count;
  logic        start_ok;
  logic        hex_error;
  logic [7:0]  last_char;
  logic [31:0] header_bits;
  logic [55:0] message_bits;
  logic [23:0] parity_bits;
  logic [23:0] crc_reg;

  logic        is_eol;
  logic        char_take;
  logic        in_frame;
  logic [4:0]  hex;
  logic [3:0]  nib;

  assign is_eol    = (beat.kind == KIND_EOL);
  // An end of line waits for room in the result register; characters never do.
  assign beat_take = beat_valid && (!is_eol || res_ready);
  assign res_valid = beat_valid && is_eol && res_ready;
  assign char_take = beat_take && !is_eol;
  assign in_frame  = (char_count >= 5'd1) && (char_count <= HEX_LEN);
  assign hex       = hex_value(beat.char_byte);
  assign nib       = hex[4] ? 4'd0 : hex[3:0];

  always_comb begin
    res = '0;
    if (char_count != LINE_LEN || !start_ok || last_char != MARK_END) begin
      res.status = STATUS_FRAME;
    end else if (hex_error || crc_reg != parity_bits || header_bits[31:27] != FORMAT_ES) begin
      res.status = STATUS_DATA;
    end else begin
      res.status          = STATUS_OK;
      res.downlink_format = header_bits[31:27];
      res.capability      = header_bits[26:24];
      res.icao_address    = header_bits[23:0];
      res.type_code       = message_bits[55:51];
      res.payload         = message_bits;
      res.stated_parity   = parity_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || res_valid) begin
      char_count   <= '0;
      start_ok     <= 1'b0;
      hex_error    <= 1'b0;
      last_char    <= '0;
      header_bits  <= '0;
      message_bits <= '0;
      parity_bits  <= '0;
      crc_reg      <= '0;
    end else if (char_take) begin
      if (char_count == 5'd0) begin
        start_ok <= (beat.char_byte == MARK_START);
      end
      if (in_frame) begin
        if (hex[4]) begin
          hex_error <= 1'b1;
        end
        header_bits  <= {header_bits[27:0], message_bits[55:52]};
        message_bits <= {message_bits[51:0], parity_bits[23:20]};
        parity_bits  <= {parity_bits[19:0], nib};
        if (char_count <= CRC_NIBBLES) begin
          crc_reg <= crc_nibble(crc_reg, nib);
        end
      end
      last_char <= beat.char_byte;
      if (char_count != COUNT_MAX) begin
        char_count <= char_count + 5'd1;
      end
    end
  end

  `SFC_ASSERT_NOW(a_reject_zeroes, res_valid && res.status != STATUS_OK,
    res.payload == '0 && res.icao_address == '0 && res.stated_parity == '0)
  `SFC_ASSERT_NEXT(a_eol_clears, res_valid, char_count == 5'd0 && crc_reg == '0)
  `SFC_ASSERT_NEXT(a_count_steps, char_take && char_count != COUNT_MAX,
    char_count == $past(char_count) + 5'd1)
  `SFC_ASSERT_NOW(a_eol_needs_room, beat_take && is_eol, res_ready)

endmodule

[hdl/sfc_out_stage.sv]
// Result register of the squitter frame checker; holds a verdict until taken.
// Depends on sfc_pkg.
module sfc_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 res_valid,
  output logic                 res_ready,
  input  sfc_pkg::sfc_result_t res,
  output logic                 m_valid,
  input  logic                 m_ready,
  output sfc_pkg::sfc_result_t m_res
);
  import sfc_pkg::*;

  assign res_ready = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (res_ready) begin
      m_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_res <= res;
    end
  end

endmodule

[hdl/squitter_frame_check.sv]
// Top level of the squitter frame checker: input register, line checker,
// result register. Depends on sfc_pkg, sfc_in_stage, sfc_line_check, sfc_out_stage.
//
// Usage:
//   Slave channel carries one text line, one character per beat (tuser = 0,
//   tdata = character), closed by an end-of-line beat (tuser = 1).
//   Master channel gives one verdict beat per end-of-line beat, none for
//   characters. Verdict: status 0 with decoded fields, 1 for wrong length
//   or '*' / ';' markers, 2 for a bad hex digit, CRC-24 mismatch or a
//   downlink format other than 17. Fields other than status are zero
//   unless status is 0.
// Timing:
//   One beat per cycle sustained, but an end-of-line beat waits while the
//   result register is full. m_tvalid rises once the end-of-line beat has
//   gone from the input register through the verdict logic into the result
//   register. The CRC-24 advances one nibble for each of the first 22 hex
//   digits, in a single combinational update.
// Reset (rst, synchronous): empties both registers and clears the line state.
// Stall: while a verdict waits on m_tready, characters keep flowing into the
//   line state; the next end-of-line beat waits in the input register, and
//   s_tready drops only then.
module squitter_frame_check (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] char_byte
  input  logic         s_tuser,   // [0] kind: 0 character, 1 end of line
  output logic         m_tvalid,
  input  logic         m_tready,
  // [1:0] status, [6:2] downlink_format, [9:7] capability, [33:10] icao_address,
  // [38:34] type_code, [94:39] payload, [118:95] stated_parity, [119] zero
  output logic [119:0] m_tdata
);
  import sfc_pkg::*;

  sfc_beat_t   s_beat;
  sfc_beat_t   beat;
  logic        beat_valid;
  logic        beat_take;
  logic        res_valid;
  logic        res_ready;
  sfc_result_t res;
  sfc_result_t m_res;

  assign s_beat.kind      = s_tuser;
  assign s_beat.char_byte = s_tdata;

  sfc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_tvalid),
    .s_ready    (s_tready),
    .s_beat     (s_beat),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_take  (beat_take)
  );

  sfc_line_check u_check (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_take  (beat_take),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res)
  );

  sfc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_res     (m_res)
  );

  // Struct packs status into the low bits; pad to whole bytes.
  assign m_tdata = {1'b0, m_res};

endmodule

[tb/tb_squitter_frame_check.sv]
// Self-checking testbench for squitter_frame_check: drives text lines, predicts each verdict.
// Depends on sfc_pkg and the squitter_frame_check RTL; uses only the package's types and constants.
module tb_squitter_frame_check;
  import sfc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [119:0] m_tdata;

  squitter_frame_check dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // idle / stall odds in percent, per cycle
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int hold_seq = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int beats_sent = 0;
  int mismatches = 0;
  int cycle_count = 0;

  sfc_result_t verdict_q[$];
  logic [7:0]  line_buf[$];

  // line tracker, mirrors the block's per-line state
  logic [4:0]  ln_count;
  logic        ln_start_ok;
  logic        ln_hex_bad;
  logic [7:0]  ln_last;
  logic [31:0] ln_header;
  logic [55:0] ln_message;
  logic [23:0] ln_parity;
  logic [23:0] ln_crc;

  function automatic bit is_hex(input logic [7:0] ch);
    return (ch >= "0" && ch <= "9") || (ch >= "A" && ch <= "F") || (ch >= "a" && ch <= "f");
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] ch);
    logic [7:0] d;
    if (ch <= "9") d = ch - "0";
    else if (ch <= "F") d = ch - "A" + 8'd10;
    else d = ch - "a" + 8'd10;
    return d[3:0];
  endfunction

  function automatic logic [7:0] to_hex_char(input logic [3:0] nib, input bit lower);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return (lower ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
  endfunction

  // CRC-24 over one nibble, MSB first
  function automatic logic [23:0] crc24_advance(input logic [23:0] crc, input logic [3:0] nib);
    logic [23:0] r;
    logic        fb;
    r = crc;
    for (int i = 3; i >= 0; i--) begin
      fb = r[23] ^ nib[i];
      r = r << 1;
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  function automatic logic [23:0] crc24_of(input logic [87:0] bits);
    logic [23:0] r;
    r = '0;
    for (int i = 0; i < 22; i++) r = crc24_advance(r, bits[87 - 4*i -: 4]);
    return r;
  endfunction

  function automatic logic [111:0] es_frame(input logic [2:0] ca, input logic [23:0] icao,
                                            input logic [55:0] me);
    logic [87:0] head;
    head = {FORMAT_ES, ca, icao, me};
    return {head, crc24_of(head)};
  endfunction

  function automatic logic [111:0] random_es_frame();
    return es_frame(3'($urandom), 24'($urandom), {24'($urandom), 32'($urandom)});
  endfunction

  task automatic clear_line_state();
    ln_count = '0;
    ln_start_ok = 1'b0;
    ln_hex_bad = 1'b0;
    ln_last = '0;
    ln_header = '0;
    ln_message = '0;
    ln_parity = '0;
    ln_crc = '0;
  endtask

  // Predict the effect of one accepted beat; an end-of-line beat queues a verdict.
  task automatic advance_line(input logic kind, input logic [7:0] ch);
    sfc_result_t v;
    logic [3:0]  nib;
    if (kind == KIND_CHAR) begin
      if (ln_count == 5'd0) ln_start_ok = (ch == MARK_START);
      if (ln_count >= 5'd1 && ln_count <= HEX_LEN) begin
        nib = 4'd0;
        if (is_hex(ch)) nib = hex_nib(ch);
        else ln_hex_bad = 1'b1;
        ln_header = {ln_header[27:0], ln_message[55:52]};
        ln_message = {ln_message[51:0], ln_parity[23:20]};
        ln_parity = {ln_parity[19:0], nib};
        if (ln_count <= CRC_NIBBLES) ln_crc = crc24_advance(ln_crc, nib);
      end
      ln_last = ch;
      if (ln_count != COUNT_MAX) ln_count = ln_count + 5'd1;
    end else begin
      v = '0;
      if (ln_count != LINE_LEN || !ln_start_ok || ln_last != MARK_END) begin
        v.status = STATUS_FRAME;
      end else if (ln_hex_bad || ln_crc != ln_parity || ln_header[31:27] != FORMAT_ES) begin
        v.status = STATUS_DATA;
      end else begin
        v.status = STATUS_OK;
        v.downlink_format = ln_header[31:27];
        v.capability = ln_header[26:24];
        v.icao_address = ln_header[23:0];
        v.type_code = ln_message[55:51];
        v.payload = ln_message;
        v.stated_parity = ln_parity;
      end
      verdict_q.insert(verdict_q.size(), v);
      clear_line_state();
    end
  endtask

  // One beat on the slave side; returns at the accepting edge.
  task automatic send_beat(input logic kind, input logic [7:0] ch);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    advance_line(kind, ch);
    beats_sent++;
  endtask

  task automatic send_line_buf();
    foreach (line_buf[i]) send_beat(KIND_CHAR, line_buf[i]);
    // data byte is don't-care on end of line
    send_beat(KIND_EOL, 8'($urandom));
  endtask

  // case_mode: 0 upper, 1 lower, 2 random per digit
  task automatic build_text(input logic [111:0] frame, input int case_mode);
    bit lower;
    line_buf.delete();
    line_buf.insert(line_buf.size(), MARK_START);
    for (int i = 0; i < 28; i++) begin
      lower = (case_mode == 2) ? bit'($urandom_range(0, 1)) : (case_mode == 1);
      line_buf.insert(line_buf.size(), to_hex_char(frame[111 - 4*i -: 4], lower));
    end
    line_buf.insert(line_buf.size(), MARK_END);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- checker
  task automatic check_field(input string name, input logic [55:0] want,
                             input logic [55:0] seen);
    if (want !== seen) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    sfc_result_t want;
    sfc_result_t seen;
    if (!rst && m_tvalid && m_tready) begin
      seen = m_tdata[118:0];
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict, expected none, got %h", $time, m_tdata);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        check_field("status", 56'(want.status), 56'(seen.status));
        check_field("downlink_format", 56'(want.downlink_format), 56'(seen.downlink_format));
        check_field("capability", 56'(want.capability), 56'(seen.capability));
        check_field("icao_address", 56'(want.icao_address), 56'(seen.icao_address));
        check_field("type_code", 56'(want.type_code), 56'(seen.type_code));
        check_field("payload", want.payload, seen.payload);
        check_field("stated_parity", 56'(want.stated_parity), 56'(seen.stated_parity));
        check_field("pad bit", 56'd0, 56'(m_tdata[119]));
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_seq != hold_ack) begin
      hold_ack = hold_seq;
      hold_left = hold_cycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_good_frames();
    build_text(es_frame(3'd0, 24'h000000, 56'h0), 0);
    send_line_buf();
    build_text(es_frame(3'd7, 24'hFFFFFF, {56{1'b1}}), 1);
    send_line_buf();
    build_text(random_es_frame(), 2);
    send_line_buf();
  endtask

  task automatic test_frame_faults();
    // empty line
    line_buf.delete();
    send_line_buf();
    // one hex digit short
    build_text(random_es_frame(), 0);
    line_buf.delete(28);
    send_line_buf();
    // overlong: count saturates
    build_text(random_es_frame(), 0);
    repeat (3) line_buf.insert(line_buf.size(), "0");
    send_line_buf();
    // bad start marker
    build_text(random_es_frame(), 0);
    line_buf[0] = "#";
    send_line_buf();
    // bad end marker
    build_text(random_es_frame(), 1);
    line_buf[29] = "0";
    send_line_buf();
    // short line with a bad digit: length fault wins
    build_text(random_es_frame(), 0);
    line_buf[4] = "g";
    line_buf.delete(10);
    send_line_buf();
  endtask

  task automatic test_data_faults();
    logic [111:0] f;
    // bad digit in the header, then in the parity field
    build_text(random_es_frame(), 0);
    line_buf[5] = "g";
    send_line_buf();
    build_text(random_es_frame(), 0);
    line_buf[27] = 8'hFF;
    send_line_buf();
    // high byte, never a hex digit
    build_text(random_es_frame(), 0);
    line_buf[15] = 8'h80;
    send_line_buf();
    // CRC off by one bit
    f = random_es_frame();
    f[0] = ~f[0];
    build_text(f, 0);
    send_line_buf();
    // formats 0 and 31 with a good CRC
    f = random_es_frame();
    f[111:107] = 5'd0;
    f[23:0] = crc24_of(f[111:24]);
    build_text(f, 0);
    send_line_buf();
    f[111:107] = 5'd31;
    f[23:0] = crc24_of(f[111:24]);
    build_text(f, 1);
    send_line_buf();
  endtask

  task automatic make_random_line();
    int          r;
    int          n;
    int          p;
    logic [111:0] f;
    r = $urandom_range(0, 99);
    f = random_es_frame();
    if (r < 55) begin
      build_text(f, 2);
    end else if (r < 62) begin
      f[23:0] = f[23:0] ^ (24'd1 << $urandom_range(0, 23));
      build_text(f, 2);
    end else if (r < 68) begin
      f[111:107] = 5'($urandom);
      f[23:0] = crc24_of(f[111:24]);
      build_text(f, 2);
    end else if (r < 74) begin
      build_text(f, 2);
      line_buf[$urandom_range(1, 28)] = 8'($urandom);
    end else if (r < 80) begin
      build_text(f, 2);
      n = $urandom_range(1, 4);
      if ($urandom_range(0, 1)) begin
        repeat (n) line_buf.delete($urandom_range(1, line_buf.size() - 2));
      end else begin
        repeat (n) line_buf.insert($urandom_range(1, 28), to_hex_char(4'($urandom), 0));
      end
    end else if (r < 86) begin
      build_text(f, 2);
      p = $urandom_range(0, 1) ? 0 : 29;
      line_buf[p] = $urandom_range(0, 1) ? 8'($urandom) : (p == 0 ? MARK_END : MARK_START);
    end else if (r < 92) begin
      line_buf.delete();
      n = $urandom_range(0, 35);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 3))
          0: line_buf.insert(line_buf.size(), MARK_START);
          1: line_buf.insert(line_buf.size(), MARK_END);
          2: line_buf.insert(line_buf.size(),
                             to_hex_char(4'($urandom), bit'($urandom_range(0, 1))));
          default: line_buf.insert(line_buf.size(), 8'($urandom));
        endcase
      end
    end else begin
      build_text(f, 2);
      line_buf[$urandom_range(0, 29)] = 8'($urandom);
    end
  endtask

  task automatic test_random_traffic(input int idle, input int stall, input int n_beats);
    int start;
    send_idle_pct = idle;
    stall_pct = stall;
    start = beats_sent;
    while (beats_sent - start < n_beats) begin
      make_random_line();
      send_line_buf();
    end
    wait_drained();
  endtask

  // Receiver blocked for a long stretch: verdict register fills, the next
  // end of line parks in the input register and s_tready must drop.
  task automatic test_output_hold();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 300;
    hold_seq++;
    repeat (12) begin
      build_text(random_es_frame(), 2);
      send_line_buf();
    end
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = KIND_CHAR;
    clear_line_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_good_frames();
    test_frame_faults();
    test_data_faults();
    wait_drained();
    test_random_traffic(0, 0, 250);
    test_random_traffic(60, 0, 250);
    test_output_hold();
    test_random_traffic(0, 60, 250);
    test_random_traffic(16, 16, 250);
    wait_drained();

    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
